[hw/rtl/nmtr_pkg.sv]
// Shared types, codes and constants for the nearest-marker table with removal.
// Used by every module of the block; depends on nothing.
package nmtr_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int LAT_W      = 15;
    localparam int LON_W      = 16;
    localparam int PIX_W      = 12;
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int ECOUNT_W   = 7;
    localparam int DIST_W     = 14;

    // Reset values of the map registers
    localparam int WIDTH_RST  = 360;
    localparam int HEIGHT_RST = 180;
    localparam int OFFSET_RST = 0;

    // Projection constants, hundredths of a degree
    localparam int LON_HALF = 18000;
    localparam int LON_SPAN = 36000;
    localparam int LAT_HALF = 9000;
    localparam int LAT_SPAN = 18000;

    // Row product is biased by FLOOR_OFS * LAT_SPAN so the divide sees a
    // non-negative value; FLOOR_OFS comes back off the quotient.
    localparam int FLOOR_OFS = 1680;
    localparam int Y_BIAS    = FLOOR_OFS * LAT_SPAN;

    // Exact divide by constant: floor(a / D) = (a * ceil(2^S / D)) >> S
    // for all a below 2^MUL_IN_W.
    localparam int MUL_IN_W      = 28;
    localparam int RECIP_W       = 29;
    localparam int PROD_W        = MUL_IN_W + RECIP_W;
    localparam int RECIP_X_SHIFT = 44;
    localparam int RECIP_Y_SHIFT = 43;
    localparam longint unsigned RECIP_X =
        ((64'd1 << RECIP_X_SHIFT) + 64'(LON_SPAN) - 64'd1) / 64'(LON_SPAN);
    localparam longint unsigned RECIP_Y =
        ((64'd1 << RECIP_Y_SHIFT) + 64'(LAT_SPAN) - 64'd1) / 64'(LAT_SPAN);
    localparam int YQ_W = 13;

    // Offset reduction divider
    localparam int WRAP_NUM_W = PIX_W + 1;
    localparam int WRAP_CNT_W = $clog2(WRAP_NUM_W + 1);

    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic signed [LAT_W-1:0]  lat_t;
    typedef logic signed [LON_W-1:0]  lon_t;
    typedef logic [PIX_W-1:0]         pix_t;
    typedef logic [DIST_W-1:0]        dist_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_CLEAR  = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_OFFSET = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRAP,
        S_SCAN,
        S_DRAIN,
        S_SHIFT
    } state_t;

    typedef struct packed {
        logic  en;
        addr_t addr;
        lat_t  lat;
        lon_t  lon;
    } mem_wr_t;

    typedef struct packed {
        pix_t width;
        pix_t height;
        pix_t wrap;
        pix_t tx;
        pix_t ty;
    } proj_cfg_t;

    typedef struct packed {
        logic  valid;
        addr_t idx;
        lat_t  lat;
        lon_t  lon;
        dist_t distance;
    } cand_t;

endpackage

[hw/rtl/nearest_marker_table_remove_unit.sv]
// Nearest-marker table with removal: top level, control sequencer and registers.
// Instantiates nmtr_store, nmtr_wrap and nmtr_proj; uses nmtr_pkg.
//
// Usage:
//   Command channel: a transfer happens on a rising edge with start high and
//   busy low. action selects append, remove-nearest or clear.
//   Result channel: done is high for exactly one cycle with status,
//   entry_count and the removed coordinates; there is no backpressure.
//   Config port: cfg_write with cfg_index/cfg_data writes map width, height
//   or offset in that cycle. Write only while the block is idle.
// Command timing:
//   Append, clear and unused codes: done in the cycle after the transfer;
//   busy stays low, so a new command may follow every cycle.
//   Remove on an empty table: likewise done in the cycle after the transfer.
//   Remove with n markers: busy through the offset reduction (13 divide
//   steps and a done step), one RAM read per marker, a drain of the RAM
//   read register and the 4-stage distance pipeline, one read/write per
//   entry moved down, and a closing step.
// Reset: table empty, map registers 360 / 180 / 0; RAM contents are not
//   cleared, only entries below the count are ever read.
module nearest_marker_table_remove_unit import nmtr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // command
    input  logic                 start,
    output logic                 busy,
    input  logic [ACTION_W-1:0]  action,
    input  lat_t                 new_latitude,
    input  lon_t                 new_longitude,
    input  pix_t                 target_x,
    input  pix_t                 target_y,
    // config writes
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  pix_t                 cfg_data,
    // result
    output logic                 done,
    output logic [STATUS_W-1:0]  status,
    output logic [ECOUNT_W-1:0]  entry_count,
    output lat_t                 removed_latitude,
    output lon_t                 removed_longitude
);

    state_t                state_reg, state_next;

    // map configuration
    pix_t                  width_reg, width_next;
    pix_t                  height_reg, height_next;
    pix_t                  offset_reg, offset_next;
    pix_t                  width_eff;

    // table bookkeeping
    cnt_t                  count_reg, count_next;
    cnt_t                  last_cnt;
    cnt_t                  scan_cnt_reg, scan_cnt_next;
    cnt_t                  sh_cnt_reg, sh_cnt_next;

    // per-remove operands
    pix_t                  tx_reg, tx_next;
    pix_t                  ty_reg, ty_next;
    pix_t                  wrap_reg, wrap_next;

    // scan read tracking
    logic                  rd_scan_reg, rd_scan_next;
    addr_t                 rd_idx_reg, rd_idx_next;

    // running best candidate
    addr_t                 best_idx_reg, best_idx_next;
    dist_t                 best_dist_reg, best_dist_next;
    lat_t                  best_lat_reg, best_lat_next;
    lon_t                  best_lon_reg, best_lon_next;
    logic                  take_best;

    // compaction write-back
    logic                  wb_valid_reg, wb_valid_next;
    addr_t                 wb_addr_reg, wb_addr_next;

    // result registers
    logic                  done_reg, done_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [ECOUNT_W-1:0]   ecount_reg, ecount_next;
    lat_t                  rlat_reg, rlat_next;
    lon_t                  rlon_reg, rlon_next;

    // unit hookups
    logic                  accept;
    logic                  scan_end;
    mem_wr_t               mem_wr;
    logic                  rd_en;
    addr_t                 rd_addr;
    lat_t                  store_lat;
    lon_t                  store_lon;
    logic                  wrap_start;
    logic                  wrap_done;
    pix_t                  wrap_rem;
    logic [WRAP_NUM_W-1:0] wrap_dividend;
    proj_cfg_t             proj_cfg;
    cand_t                 cand;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign width_eff = (width_reg == '0) ? PIX_W'(1) : width_reg;
    assign last_cnt  = count_reg - 1'b1;
    assign scan_end  = cand.valid && (CNT_W'(cand.idx) == last_cnt);

    // rotation constant (offset + width/2) mod width
    assign wrap_dividend = WRAP_NUM_W'(offset_reg) + WRAP_NUM_W'(width_eff >> 1);

    assign proj_cfg.width  = width_eff;
    assign proj_cfg.height = height_reg;
    assign proj_cfg.wrap   = wrap_reg;
    assign proj_cfg.tx     = tx_reg;
    assign proj_cfg.ty     = ty_reg;

    nmtr_store u_store
    (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_lat  (store_lat),
        .rd_lon  (store_lon)
    );

    nmtr_wrap u_wrap
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (wrap_start),
        .dividend  (wrap_dividend),
        .divisor   (width_eff),
        .done      (wrap_done),
        .remainder (wrap_rem)
    );

    nmtr_proj u_proj
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rd_scan_reg),
        .in_idx   (rd_idx_reg),
        .in_lat   (store_lat),
        .in_lon   (store_lon),
        .cfg      (proj_cfg),
        .cand     (cand)
    );

    // First strict minimum wins: slot 0 always seeds the search.
    assign take_best      = cand.valid &&
                            ((cand.idx == '0) || (cand.distance < best_dist_reg));
    assign best_idx_next  = take_best ? cand.idx      : best_idx_reg;
    assign best_dist_next = take_best ? cand.distance : best_dist_reg;
    assign best_lat_next  = take_best ? cand.lat      : best_lat_reg;
    assign best_lon_next  = take_best ? cand.lon      : best_lon_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (action_t'(action) == ACT_REMOVE) && (count_reg != '0))
                begin
                    state_next = S_WRAP;
                end
            end
            S_WRAP:
            begin
                if (wrap_done)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_cnt_reg == last_cnt)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (scan_end)
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (sh_cnt_reg >= count_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath control and register updates
    always_comb
    begin
        width_next    = width_reg;
        height_next   = height_reg;
        offset_next   = offset_reg;
        count_next    = count_reg;
        scan_cnt_next = scan_cnt_reg;
        sh_cnt_next   = sh_cnt_reg;
        tx_next       = tx_reg;
        ty_next       = ty_reg;
        wrap_next     = wrap_reg;
        rd_scan_next  = 1'b0;
        rd_idx_next   = rd_idx_reg;
        wb_valid_next = 1'b0;
        wb_addr_next  = wb_addr_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        ecount_next   = ecount_reg;
        rlat_next     = rlat_reg;
        rlon_next     = rlon_reg;
        wrap_start    = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = scan_cnt_reg[ADDR_W-1:0];
        mem_wr.en     = 1'b0;
        mem_wr.addr   = count_reg[ADDR_W-1:0];
        mem_wr.lat    = new_latitude;
        mem_wr.lon    = new_longitude;

        if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_WIDTH:  width_next  = cfg_data;
                CFG_HEIGHT: height_next = cfg_data;
                CFG_OFFSET: offset_next = cfg_data;
                default:    ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next   = 1'b1;
                    status_next = ST_DONE;
                    rlat_next   = '0;
                    rlon_next   = '0;
                    ecount_next = ECOUNT_W'(count_reg);
                    tx_next     = target_x;
                    ty_next     = target_y;
                    case (action_t'(action))
                        ACT_APPEND:
                        begin
                            if (count_reg >= CNT_W'(TABLE_DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_wr.en   = 1'b1;
                                count_next  = count_reg + 1'b1;
                                ecount_next = ECOUNT_W'(count_reg + 1'b1);
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                wrap_start = 1'b1;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next  = '0;
                            ecount_next = '0;
                        end
                        default:
                        begin
                            // unused code: report only
                        end
                    endcase
                end
            end
            S_WRAP:
            begin
                if (wrap_done)
                begin
                    wrap_next     = wrap_rem;
                    scan_cnt_next = '0;
                end
            end
            S_SCAN:
            begin
                rd_en         = 1'b1;
                rd_addr       = scan_cnt_reg[ADDR_W-1:0];
                rd_scan_next  = 1'b1;
                rd_idx_next   = scan_cnt_reg[ADDR_W-1:0];
                scan_cnt_next = scan_cnt_reg + 1'b1;
            end
            S_DRAIN:
            begin
                if (scan_end)
                begin
                    sh_cnt_next = CNT_W'(best_idx_next) + 1'b1;
                end
            end
            S_SHIFT:
            begin
                if (sh_cnt_reg < count_reg)
                begin
                    // read slot j now, write it to slot j-1 next cycle
                    rd_en         = 1'b1;
                    rd_addr       = sh_cnt_reg[ADDR_W-1:0];
                    sh_cnt_next   = sh_cnt_reg + 1'b1;
                    wb_valid_next = 1'b1;
                    wb_addr_next  = sh_cnt_reg[ADDR_W-1:0] - 1'b1;
                end
                else
                begin
                    count_next  = last_cnt;
                    done_next   = 1'b1;
                    status_next = ST_DONE;
                    ecount_next = ECOUNT_W'(last_cnt);
                    rlat_next   = best_lat_reg;
                    rlon_next   = best_lon_reg;
                end
            end
            default:
            begin
            end
        endcase

        if (wb_valid_reg)
        begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = wb_addr_reg;
            mem_wr.lat  = store_lat;
            mem_wr.lon  = store_lon;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            width_reg    <= PIX_W'(WIDTH_RST);
            height_reg   <= PIX_W'(HEIGHT_RST);
            offset_reg   <= PIX_W'(OFFSET_RST);
            count_reg    <= '0;
            rd_scan_reg  <= 1'b0;
            wb_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            offset_reg   <= offset_next;
            count_reg    <= count_next;
            rd_scan_reg  <= rd_scan_next;
            wb_valid_reg <= wb_valid_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_cnt_reg  <= scan_cnt_next;
        sh_cnt_reg    <= sh_cnt_next;
        tx_reg        <= tx_next;
        ty_reg        <= ty_next;
        wrap_reg      <= wrap_next;
        rd_idx_reg    <= rd_idx_next;
        wb_addr_reg   <= wb_addr_next;
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
        best_lat_reg  <= best_lat_next;
        best_lon_reg  <= best_lon_next;
        status_reg    <= status_next;
        ecount_reg    <= ecount_next;
        rlat_reg      <= rlat_next;
        rlon_reg      <= rlon_next;
    end

    assign done              = done_reg;
    assign status            = status_reg;
    assign entry_count       = ecount_reg;
    assign removed_latitude  = rlat_reg;
    assign removed_longitude = rlon_reg;

endmodule

[hw/rtl/nmtr_store.sv]
// Marker table storage: one synchronous RAM of latitude/longitude pairs.
// One write port, one read port with registered read data. Uses nmtr_pkg.
module nmtr_store import nmtr_pkg::*;
(
    input  logic    clk,
    input  mem_wr_t wr,
    input  logic    rd_en,
    input  addr_t   rd_addr,
    output lat_t    rd_lat,
    output lon_t    rd_lon
);

    logic [LAT_W+LON_W-1:0] mem [TABLE_DEPTH];
    logic [LAT_W+LON_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= {wr.lat, wr.lon};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_lat = lat_t'(rd_data_reg[LAT_W+LON_W-1:LON_W]);
    assign rd_lon = lon_t'(rd_data_reg[LON_W-1:0]);

endmodule

[hw/rtl/nmtr_wrap.sv]
// Bit-serial remainder unit: (offset + width/2) mod width, one bit per cycle.
// Uses nmtr_pkg.
module nmtr_wrap import nmtr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [WRAP_NUM_W-1:0] dividend,
    input  pix_t                  divisor,
    output logic                  done,
    output pix_t                  remainder
);

    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [WRAP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [WRAP_NUM_W-1:0] num_reg, num_next;
    pix_t                  rem_reg, rem_next;
    logic [WRAP_NUM_W-1:0] trial;
    logic [WRAP_NUM_W-1:0] trial_sub;

    assign trial     = {rem_reg, num_reg[WRAP_NUM_W-1]};
    assign trial_sub = (trial >= {1'b0, divisor}) ? (trial - {1'b0, divisor}) : trial;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = WRAP_CNT_W'(WRAP_NUM_W);
            num_next = dividend;
            rem_next = '0;
        end
        else if (run_reg)
        begin
            rem_next = trial_sub[PIX_W-1:0];
            num_next = {num_reg[WRAP_NUM_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == WRAP_CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[hw/rtl/nmtr_proj.sv]
// Four-stage projection and Manhattan distance pipeline, one marker per cycle.
// Divides by 36000 and 18000 through exact reciprocal multiplies. Uses nmtr_pkg.
module nmtr_proj import nmtr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  addr_t     in_idx,
    input  lat_t      in_lat,
    input  lon_t      in_lon,
    input  proj_cfg_t cfg,
    output cand_t     cand
);

    // stage 1: longitude folded into one turn, both products
    logic signed [LON_W+1:0]   lon_sum;
    logic [LON_W-1:0]          lon_mod;
    logic signed [LAT_W+1:0]   lat_diff;
    logic [MUL_IN_W-1:0]       x_prod_next;
    logic signed [29:0]        y_prod_next;

    logic                      v1_reg, v2_reg, v3_reg, v4_reg;
    addr_t                     idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    lat_t                      lat1_reg, lat2_reg, lat3_reg, lat4_reg;
    lon_t                      lon1_reg, lon2_reg, lon3_reg, lon4_reg;
    logic [MUL_IN_W-1:0]       x_prod_reg;
    logic signed [29:0]        y_prod_reg;

    assign lon_sum  = (LON_W+2)'(in_lon) + (LON_W+2)'(LON_HALF);
    assign lat_diff = (LAT_W+2)'(LAT_HALF) - (LAT_W+2)'(in_lat);

    always_comb
    begin
        if (lon_sum < 0)
        begin
            lon_mod = LON_W'(lon_sum + (LON_W+2)'(LON_SPAN));
        end
        else if (lon_sum >= (LON_W+2)'(LON_SPAN))
        begin
            lon_mod = LON_W'(lon_sum - (LON_W+2)'(LON_SPAN));
        end
        else
        begin
            lon_mod = LON_W'(lon_sum);
        end
    end

    assign x_prod_next = MUL_IN_W'(cfg.width) * MUL_IN_W'(lon_mod);
    assign y_prod_next = 30'($signed({1'b0, cfg.height})) * 30'(lat_diff);

    // stage 2: reciprocal multiplies
    logic [MUL_IN_W-1:0] y_biased;
    logic [PROD_W-1:0]   x_quot_prod;
    logic [PROD_W-1:0]   y_quot_prod;
    pix_t                xm_next, xm_reg;
    logic [YQ_W-1:0]     yq_next, yq_reg;

    assign y_biased    = MUL_IN_W'(y_prod_reg + 30'(Y_BIAS));
    assign x_quot_prod = PROD_W'(x_prod_reg) * PROD_W'(RECIP_X);
    assign y_quot_prod = PROD_W'(y_biased) * PROD_W'(RECIP_Y);
    assign xm_next     = x_quot_prod[RECIP_X_SHIFT +: PIX_W];
    assign yq_next     = y_quot_prod[RECIP_Y_SHIFT +: YQ_W];

    // stage 3: horizontal rotation and bias removal
    logic [PIX_W:0]            x_sum;
    pix_t                      x_next, x_reg;
    logic signed [YQ_W:0]      y_next, y_reg;

    assign x_sum  = (PIX_W+1)'(xm_reg) + (PIX_W+1)'(cfg.wrap);
    assign x_next = (x_sum >= (PIX_W+1)'(cfg.width)) ?
                    PIX_W'(x_sum - (PIX_W+1)'(cfg.width)) : PIX_W'(x_sum);
    assign y_next = $signed({1'b0, yq_reg}) - (YQ_W+1)'(FLOOR_OFS);

    // stage 4: Manhattan distance to the target
    logic signed [PIX_W:0]     dx;
    logic signed [YQ_W+1:0]    dy;
    pix_t                      dx_mag;
    logic [YQ_W-1:0]           dy_mag;
    dist_t                     dist_next, dist_reg;

    assign dx     = $signed({1'b0, x_reg}) - $signed({1'b0, cfg.tx});
    assign dy     = (YQ_W+2)'(y_reg) - $signed({3'b000, cfg.ty});
    assign dx_mag = dx[PIX_W] ? PIX_W'(-dx) : PIX_W'(dx);
    assign dy_mag = dy[YQ_W+1] ? YQ_W'(-dy) : YQ_W'(dy);
    assign dist_next = DIST_W'(dx_mag) + DIST_W'(dy_mag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg   <= in_idx;
        lat1_reg   <= in_lat;
        lon1_reg   <= in_lon;
        x_prod_reg <= x_prod_next;
        y_prod_reg <= y_prod_next;

        idx2_reg   <= idx1_reg;
        lat2_reg   <= lat1_reg;
        lon2_reg   <= lon1_reg;
        xm_reg     <= xm_next;
        yq_reg     <= yq_next;

        idx3_reg   <= idx2_reg;
        lat3_reg   <= lat2_reg;
        lon3_reg   <= lon2_reg;
        x_reg      <= x_next;
        y_reg      <= y_next;

        idx4_reg   <= idx3_reg;
        lat4_reg   <= lat3_reg;
        lon4_reg   <= lon3_reg;
        dist_reg   <= dist_next;
    end

    assign cand.valid    = v4_reg;
    assign cand.idx      = idx4_reg;
    assign cand.lat      = lat4_reg;
    assign cand.lon      = lon4_reg;
    assign cand.distance = dist_reg;

endmodule

[hw/rtl/nmtr_chk.sv]
// Port-level checker for the nearest-marker table, bound to the top level.
// Uses nmtr_pkg.
module nmtr_chk import nmtr_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic [ACTION_W-1:0] action,
    input logic                done,
    input logic [STATUS_W-1:0] status,
    input logic [ECOUNT_W-1:0] entry_count,
    input lat_t                removed_latitude,
    input lon_t                removed_longitude
);

    // non-remove commands answer on the next cycle
    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action != ACT_REMOVE)) |=> done)
        else $error("non-remove command gave no result next cycle");

    // a remove run ends with its result
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL)) |->
            ((entry_count == ECOUNT_W'(TABLE_DEPTH)) &&
             (removed_latitude == '0) && (removed_longitude == '0)))
        else $error("full status with wrong count or removed marker");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_EMPTY)) |->
            ((entry_count == '0) &&
             (removed_latitude == '0) && (removed_longitude == '0)))
        else $error("empty status with wrong count or removed marker");

endmodule

bind nearest_marker_table_remove_unit nmtr_chk u_nmtr_chk
(
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .action            (action),
    .done              (done),
    .status            (status),
    .entry_count       (entry_count),
    .removed_latitude  (removed_latitude),
    .removed_longitude (removed_longitude)
);
